// ===== rtl/core/btkx_pkg.sv =====
// ----------------------------------------------------------------------------
// btkx_pkg: shared constants and types for the binary trie k-th xor core
// Port field widths, request and status codes, and the per-level control
// group handed from the sequencer to the trie step unit.
// ----------------------------------------------------------------------------
package btkx_pkg;

   localparam int MAX_KEYS = 1024;
   localparam int KEY_BITS = 34;

   // fixed field widths of the stream payloads
   localparam int KEY_W    = 34;
   localparam int RANK_W   = 11;
   localparam int STATUS_W = 2;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_QUERY  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANK = 2'd2;

   typedef struct packed {
      logic is_query;
      logic key_bit;
      logic fresh;     // node was allocated during this insert, memory word not valid
   } step_ctrl_type;

endpackage

// ===== rtl/core/btkx_node_ram.sv =====
// ----------------------------------------------------------------------------
// btkx_node_ram: trie node store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module btkx_node_ram #(
   parameter int DEPTH  = 34817,
   parameter int ADDR_W = 16,
   parameter int WIDTH  = 54
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/btkx_step.sv =====
// ----------------------------------------------------------------------------
// btkx_step: one trie level
// Node word holds both child links and both child counts. Insert follows or
// allocates the child on the key bit side and bumps its count; query compares
// the remaining rank against the same-side count and picks a child.
// ----------------------------------------------------------------------------
module btkx_step #(
   parameter int NODE_W = 16,
   parameter int CNT_W  = 11,
   parameter int WORD_W = 2 * NODE_W + 2 * CNT_W
) (
   input  btkx_pkg::step_ctrl_type ctrl,
   input  logic [WORD_W-1:0]       word_in,
   input  logic [CNT_W-1:0]        rank_in,
   input  logic [NODE_W-1:0]       next_free,
   output logic [WORD_W-1:0]       word_out,
   output logic [NODE_W-1:0]       next_node,
   output logic [CNT_W-1:0]        rank_out,
   output logic                    ans_bit,
   output logic                    alloc
);

   logic [WORD_W-1:0] word;
   logic [NODE_W-1:0] link0, link1, link_same, link_other, link_new;
   logic [CNT_W-1:0]  cnt0, cnt1, cnt_same, cnt_new;
   logic              go_other;

   always_comb begin
      word       = ctrl.fresh ? '0 : word_in;
      link0      = word[NODE_W-1:0];
      link1      = word[2*NODE_W-1:NODE_W];
      cnt0       = word[2*NODE_W+CNT_W-1:2*NODE_W];
      cnt1       = word[WORD_W-1:2*NODE_W+CNT_W];
      link_same  = ctrl.key_bit ? link1 : link0;
      link_other = ctrl.key_bit ? link0 : link1;
      cnt_same   = ctrl.key_bit ? cnt1 : cnt0;

      // insert path
      alloc    = !ctrl.is_query && (link_same == '0);
      link_new = alloc ? next_free : link_same;
      cnt_new  = cnt_same + CNT_W'(1);
      word_out = word;
      if (ctrl.key_bit) begin
         word_out[2*NODE_W-1:NODE_W]       = link_new;
         word_out[WORD_W-1:2*NODE_W+CNT_W] = cnt_new;
      end else begin
         word_out[NODE_W-1:0]                  = link_new;
         word_out[2*NODE_W+CNT_W-1:2*NODE_W]   = cnt_new;
      end

      // query path
      go_other = ctrl.is_query && (rank_in > cnt_same);
      rank_out = go_other ? rank_in - cnt_same : rank_in;
      ans_bit  = go_other;

      if (ctrl.is_query) begin
         next_node = go_other ? link_other : link_same;
      end else begin
         next_node = link_new;
      end
   end

endmodule

// ===== rtl/core/binary_trie_kth_xor_core.sv =====
// ----------------------------------------------------------------------------
// binary_trie_kth_xor_core: binary trie with insert and k-th smallest xor
// Request stream: req_tuser is the request type (insert or query), req_tdata
// carries key and rank. One response per request: rsp_tdata is the xor value,
// rsp_tuser the status (ok, store full, rank out of range).
// Once a request is taken, the sequencer walks the trie one level per cycle
// from the top key bit down through the step unit and the node memory, over
// all KEY_BITS levels (34 by default), then loads the response. The walk is
// bound by the node memory read, one level a cycle, each level's address
// coming from the last. Rejected requests skip the walk and go straight to
// the response load.
// req_tready is high only while no request is in progress. The response sits
// in an output register; the next request may be taken while it waits, and
// that request's result waits until rsp_tready frees the register.
// Reset empties the trie at once: the root is held in registers and nodes are
// allocated in order, so memory words never written are never trusted.
// ----------------------------------------------------------------------------
module binary_trie_kth_xor_core #(
   parameter int MAX_KEYS = btkx_pkg::MAX_KEYS,
   parameter int KEY_BITS = btkx_pkg::KEY_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // [33:0] key, [44:34] rank, zero pad
   input  logic        req_tuser,   // [0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [33:0] xor_value, zero pad
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   localparam int NODE_COUNT = MAX_KEYS * KEY_BITS + 1;
   localparam int NODE_W     = $clog2(NODE_COUNT + 1);
   localparam int CNT_W      = $clog2(MAX_KEYS + 1);
   localparam int WORD_W     = 2 * NODE_W + 2 * CNT_W;
   localparam int LVL_W      = $clog2(KEY_BITS);
   localparam int RANK_W     = btkx_pkg::RANK_W;
   localparam int CMP_W      = (CNT_W > RANK_W) ? CNT_W : RANK_W;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WALK = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [LVL_W-1:0]    level_ff, level_in;
   logic                at_root_ff, at_root_in;
   logic                fresh_ff, fresh_in;
   logic                op_ff, op_in;
   logic [NODE_W-1:0]   node_ff, node_in;
   logic [CNT_W-1:0]    rank_ff, rank_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [KEY_BITS-1:0] ans_ff, ans_in;
   logic [NODE_W-1:0]   next_free_ff, next_free_in;
   logic [CNT_W-1:0]    stored_ff, stored_in;
   logic [WORD_W-1:0]   root_word_ff, root_word_in;
   logic [btkx_pkg::STATUS_W-1:0] status_ff, status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [btkx_pkg::KEY_W-1:0]    rsp_xor_ff, rsp_xor_in;
   logic [btkx_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic                    req_accept, walking, rsp_load;
   logic [CMP_W-1:0]        rank_ext, stored_ext;
   btkx_pkg::step_ctrl_type step_ctrl;
   logic [WORD_W-1:0]       step_word_in, step_word_out, ram_rd_data;
   logic [NODE_W-1:0]       step_next_node;
   logic [CNT_W-1:0]        step_rank_out;
   logic                    step_ans_bit, step_alloc;
   logic                    ram_wr_en;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign walking    = (state_ff == ST_WALK);
   assign rsp_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   assign rank_ext   = CMP_W'(req_tdata[44:34]);
   assign stored_ext = CMP_W'(stored_ff);

   assign step_ctrl.is_query = (op_ff == btkx_pkg::REQ_QUERY);
   assign step_ctrl.key_bit  = key_ff[level_ff];
   assign step_ctrl.fresh    = fresh_ff;
   assign step_word_in       = at_root_ff ? root_word_ff : ram_rd_data;

   btkx_step #(
      .NODE_W (NODE_W),
      .CNT_W  (CNT_W),
      .WORD_W (WORD_W)
   ) u_step (
      .ctrl      (step_ctrl),
      .word_in   (step_word_in),
      .rank_in   (rank_ff),
      .next_free (next_free_ff),
      .word_out  (step_word_out),
      .next_node (step_next_node),
      .rank_out  (step_rank_out),
      .ans_bit   (step_ans_bit),
      .alloc     (step_alloc)
   );

   assign ram_wr_en = walking && !at_root_ff && (op_ff == btkx_pkg::REQ_INSERT);

   btkx_node_ram #(
      .DEPTH  (NODE_COUNT),
      .ADDR_W (NODE_W),
      .WIDTH  (WORD_W)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (node_ff),
      .wr_data (step_word_out),
      .rd_en   (walking),
      .rd_addr (step_next_node),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      level_in      = level_ff;
      at_root_in    = at_root_ff;
      fresh_in      = fresh_ff;
      op_in         = op_ff;
      node_in       = node_ff;
      rank_in       = rank_ff;
      key_in        = key_ff;
      ans_in        = ans_ff;
      next_free_in  = next_free_ff;
      stored_in     = stored_ff;
      root_word_in  = root_word_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_xor_in    = rsp_xor_ff;
      rsp_status_in = rsp_status_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               op_in      = req_tuser;
               key_in     = KEY_BITS'(req_tdata[33:0]);
               rank_in    = CNT_W'(req_tdata[44:34]);
               ans_in     = '0;
               level_in   = LVL_W'(KEY_BITS - 1);
               at_root_in = 1'b1;
               fresh_in   = 1'b0;
               status_in  = btkx_pkg::STATUS_OK;
               state_in   = ST_WALK;
               if (req_tuser == btkx_pkg::REQ_INSERT) begin
                  if (stored_ff == CNT_W'(MAX_KEYS)) begin
                     status_in = btkx_pkg::STATUS_FULL;
                     state_in  = ST_DONE;
                  end
               end else if ((rank_ext == '0) || (rank_ext > stored_ext)) begin
                  status_in = btkx_pkg::STATUS_RANK;
                  state_in  = ST_DONE;
               end
            end
         end
         ST_WALK: begin
            node_in    = step_next_node;
            rank_in    = step_rank_out;
            at_root_in = 1'b0;
            ans_in     = ans_ff | (KEY_BITS'(step_ans_bit) << level_ff);
            if (op_ff == btkx_pkg::REQ_INSERT) begin
               fresh_in = fresh_ff || step_alloc;
               if (step_alloc) begin
                  next_free_in = next_free_ff + NODE_W'(1);
               end
               if (at_root_ff) begin
                  root_word_in = step_word_out;
               end
            end
            if (level_ff == '0) begin
               if (op_ff == btkx_pkg::REQ_INSERT) begin
                  stored_in = stored_ff + CNT_W'(1);
               end
               state_in = ST_DONE;
            end else begin
               level_in = level_ff - LVL_W'(1);
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               rsp_valid_in  = 1'b1;
               rsp_xor_in    = btkx_pkg::KEY_W'(ans_ff);
               rsp_status_in = status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         next_free_ff <= NODE_W'(1);
         stored_ff    <= '0;
         root_word_ff <= '0;
         rsp_valid_ff <= 1'b0;
         at_root_ff   <= 1'b0;
         fresh_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         next_free_ff <= next_free_in;
         stored_ff    <= stored_in;
         root_word_ff <= root_word_in;
         rsp_valid_ff <= rsp_valid_in;
         at_root_ff   <= at_root_in;
         fresh_ff     <= fresh_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff      <= level_in;
      op_ff         <= op_in;
      node_ff       <= node_in;
      rank_ff       <= rank_in;
      key_ff        <= key_in;
      ans_ff        <= ans_in;
      status_ff     <= status_in;
      rsp_xor_ff    <= rsp_xor_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_xor_ff};
   assign rsp_tuser  = rsp_status_ff;

   // allocation never runs past the node store
   a_node_bound: assert property (@(posedge clock) disable iff (reset)
      $unsigned(next_free_ff) <= NODE_COUNT)
      else $error("node allocation past end of store");

   a_key_bound: assert property (@(posedge clock) disable iff (reset)
      $unsigned(stored_ff) <= MAX_KEYS)
      else $error("stored key count above capacity");

   // below the root the walk always sits on an allocated node
   a_walk_node: assert property (@(posedge clock) disable iff (reset)
      walking && !at_root_ff |-> node_ff != '0)
      else $error("trie walk reached a missing node");

   a_fresh_insert: assert property (@(posedge clock) disable iff (reset)
      walking && fresh_ff |-> op_ff == btkx_pkg::REQ_INSERT)
      else $error("fresh node flag set outside insert");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != btkx_pkg::STATUS_OK |-> rsp_xor_ff == '0)
      else $error("error response with nonzero xor value");

endmodule
